### src/gds_pkg.sv
// gds_pkg: widths, register map, reset values and codes for the grid diffusion stencil.
// No dependencies; imported by grid_diffusion_stencil and tb.

package gds_pkg;

   // Payload and register widths
   localparam int CELL_W      = 32;
   localparam int COEFF_W     = 15;
   localparam int LEN_W       = 6;
   localparam int CNT_W       = 13;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int REG_IDX_W   = 2;

   // Default sizes
   localparam int DEF_MAX_LINE  = 32;
   localparam int DEF_MAX_LINES = 4096;

   // Smallest grid dimension
   localparam int MIN_DIM = 2;

   // Arithmetic: Q16.16 cells, Q0.16 coefficient
   localparam int DIFF_W   = CELL_W + 3;          // up+dn+lf+rt-4c, signed
   localparam int MULT_W   = DIFF_W + COEFF_W + 1;
   localparam int PROD_W   = 50;                  // |product| < 2^48
   localparam int FRAC_W   = 16;
   localparam int DELTA_W  = PROD_W - FRAC_W;
   localparam int RES_W    = DELTA_W + 2;
   localparam longint ROUND_HALF = 64'd32768;

   localparam logic [COEFF_W-1:0] COEFF_MAX     = 15'd16384;
   localparam logic [COEFF_W-1:0] COEFF_RESET   = '0;
   localparam logic [LEN_W-1:0]   LEN_RESET     = 6'd32;
   localparam logic [CNT_W-1:0]   CNT_RESET     = 13'd2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_COEFF = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEN   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CNT   = 2'd2;

   // Result queue
   localparam int FIFO_DEPTH = 8;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0] value;
      logic              last;
   } result_type;

endpackage

### src/grid_diffusion_stencil.sv
// A result passes the stage 1, 2 and 3 registers and the result queue before it is offered.
// Throughput: one cell per cycle while the result queue has credit; the last cell of a grid
// is followed by a drain of the final line from the line memories, while req_tready is low.
// Rate is set by the line memories: two read ports on the current line, one on the previous.
// Reset (synchronous, active high) clears position, pipeline, queue and registers to their
// reset values; the line memories are not cleared.
//
// grid_diffusion_stencil: five-point explicit diffusion over a raster-streamed grid.
// Depends on gds_pkg.

module grid_diffusion_stencil #(
   parameter int MAX_LINE  = gds_pkg::DEF_MAX_LINE,
   parameter int MAX_LINES = gds_pkg::DEF_MAX_LINES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gds_pkg::CELL_W-1:0]     req_tdata,     // [31:0] cell_value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gds_pkg::CELL_W-1:0]     rsp_tdata,     // [31:0] new_value
   output logic                           rsp_tlast,     // grid_done
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gds_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gds_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gds_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import gds_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LINE);
   localparam int ROW_W  = $clog2(MAX_LINES);
   localparam int CW     = (ROW_W + 1 > CNT_W) ? ROW_W + 1 : CNT_W;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic              flush;
      logic              row1;
      logic              first_col;
      logic              last_col;
      logic              done;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] x;
   } slot_type;

   // ---------------- configuration ----------------
   logic [COEFF_W-1:0]   coeff_ff, coeff_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 cfg_restart;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg_restart = csr_wr && (csr_idx == REG_LEN || csr_idx == REG_CNT);

   always_comb begin
      coeff_in = coeff_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_COEFF: coeff_in = csr_pwdata[COEFF_W-1:0];
            REG_LEN:   len_in   = csr_pwdata[LEN_W-1:0];
            REG_CNT:   cnt_in   = csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_COEFF: csr_prdata = CSR_DATA_W'(coeff_ff);
         REG_LEN:   csr_prdata = CSR_DATA_W'(len_ff);
         REG_CNT:   csr_prdata = CSR_DATA_W'(cnt_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_RESET;
         len_ff   <= LEN_RESET;
         cnt_ff   <= CNT_RESET;
      end else begin
         coeff_ff <= coeff_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Effective sizes and coefficient
   logic [LEN_W-1:0]   eff_len;
   logic [CW-1:0]      eff_cnt;
   logic [ADDR_W-1:0]  col_last;
   logic [ROW_W-1:0]   row_last;
   logic [COEFF_W-1:0] d_eff;

   always_comb begin
      if (len_ff < LEN_W'(MIN_DIM))
         eff_len = LEN_W'(MIN_DIM);
      else if (len_ff > LEN_W'(MAX_LINE))
         eff_len = LEN_W'(MAX_LINE);
      else
         eff_len = len_ff;
      if (CW'(cnt_ff) < CW'(MIN_DIM))
         eff_cnt = CW'(MIN_DIM);
      else if (CW'(cnt_ff) > CW'(MAX_LINES))
         eff_cnt = CW'(MAX_LINES);
      else
         eff_cnt = CW'(cnt_ff);
      d_eff = (coeff_ff > COEFF_MAX) ? COEFF_MAX : coeff_ff;
   end

   assign col_last = ADDR_W'(eff_len - LEN_W'(1));
   assign row_last = ROW_W'(eff_cnt - CW'(1));

   // ---------------- issue control ----------------
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              credit_ok, in_fire, flush_fire, emit_issue, out_fire;
   logic              at_col_last, at_row_last;
   logic [ADDR_W-1:0] col_nb;

   assign credit_ok   = pending_ff < PEND_W'(FIFO_DEPTH);
   assign req_tready  = (state_ff == ST_RUN) && credit_ok;
   assign in_fire     = req_tvalid && req_tready;
   assign flush_fire  = (state_ff == ST_FLUSH) && credit_ok;
   assign at_col_last = col_ff == col_last;
   assign at_row_last = row_ff == row_last;
   assign emit_issue  = (in_fire && row_ff != '0) || flush_fire;
   assign col_nb      = at_col_last ? col_ff : col_ff + ADDR_W'(1);

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_RUN: begin
            if (in_fire) begin
               if (at_col_last) begin
                  col_in = '0;
                  if (at_row_last) begin
                     row_in   = '0;
                     state_in = ST_FLUSH;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  col_in = col_ff + ADDR_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            // column counter walks the final line once more
            if (flush_fire) begin
               if (at_col_last) begin
                  col_in   = '0;
                  state_in = ST_RUN;
               end else begin
                  col_in = col_ff + ADDR_W'(1);
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign pending_in = pending_ff + PEND_W'(emit_issue) - PEND_W'(out_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         col_ff     <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
      end
   end

   // ---------------- line memories ----------------
   logic [CELL_W-1:0] cur_mem  [MAX_LINE];
   logic [CELL_W-1:0] prev_mem [MAX_LINE];
   logic [CELL_W-1:0] cur_rd0_ff, cur_rd1_ff, prev_rd_ff;

   slot_type          s1_ff, s1_in;
   logic              s1_valid_ff;
   logic              prev_wr;

   // read-first: a read of the entry being written returns the older line
   always_ff @(posedge clock) begin
      if (in_fire)
         cur_mem[col_ff] <= req_tdata;
      cur_rd0_ff <= cur_mem[col_ff];
      cur_rd1_ff <= cur_mem[col_nb];
   end

   assign prev_wr = s1_valid_ff && !s1_ff.flush;

   always_ff @(posedge clock) begin
      if (prev_wr)
         prev_mem[s1_ff.addr] <= cur_rd0_ff;
      prev_rd_ff <= prev_mem[col_ff];
   end

   // ---------------- stage 1: neighbour select and sum ----------------
   always_comb begin
      s1_in.flush     = flush_fire;
      s1_in.row1      = row_ff == ROW_W'(1);
      s1_in.first_col = col_ff == '0;
      s1_in.last_col  = at_col_last;
      s1_in.done      = flush_fire && at_col_last;
      s1_in.addr      = col_ff;
      s1_in.x         = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= emit_issue;
      s1_ff <= s1_in;
   end

   logic [CELL_W-1:0]       left_ff;
   logic [CELL_W-1:0]       ctr, lf, rt, up, dn;
   logic [CELL_W+1:0]       sum4;
   logic signed [DIFF_W-1:0] diff;

   always_comb begin
      ctr = cur_rd0_ff;
      if (s1_ff.first_col) begin
         lf = cur_rd1_ff;
         rt = cur_rd1_ff;
      end else if (s1_ff.last_col) begin
         lf = left_ff;
         rt = left_ff;
      end else begin
         lf = left_ff;
         rt = cur_rd1_ff;
      end
      // second line of a grid: the missing upper row mirrors the lower one
      up   = (s1_ff.flush || !s1_ff.row1) ? prev_rd_ff : s1_ff.x;
      dn   = s1_ff.flush ? prev_rd_ff : s1_ff.x;
      sum4 = (CELL_W+2)'(up) + (CELL_W+2)'(dn) + (CELL_W+2)'(lf) + (CELL_W+2)'(rt);
      diff = $signed({1'b0, sum4}) - $signed({1'b0, ctr, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff)
         left_ff <= ctr;
   end

   // ---------------- stage 2: multiply ----------------
   logic                     s2_valid_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff;
   logic [CELL_W-1:0]        s2_ctr_ff;
   logic                     s2_done_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else
         s2_valid_ff <= s1_valid_ff;
      s2_diff_ff <= diff;
      s2_ctr_ff  <= ctr;
      s2_done_ff <= s1_ff.done;
   end

   logic signed [MULT_W-1:0] prod_full;
   assign prod_full = s2_diff_ff * $signed({1'b0, d_eff});

   // ---------------- stage 3: round, add, saturate ----------------
   logic                     s3_valid_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;
   logic [CELL_W-1:0]        s3_ctr_ff;
   logic                     s3_done_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s3_valid_ff <= 1'b0;
      else
         s3_valid_ff <= s2_valid_ff;
      s3_prod_ff <= prod_full[PROD_W-1:0];
      s3_ctr_ff  <= s2_ctr_ff;
      s3_done_ff <= s2_done_ff;
   end

   logic signed [PROD_W-1:0]  rounded;
   logic signed [DELTA_W-1:0] delta;
   logic signed [RES_W-1:0]   res;
   result_type                result;

   always_comb begin
      // halves go up: floor((p + half) / 2^16)
      rounded = s3_prod_ff + $signed(PROD_W'(ROUND_HALF));
      delta   = rounded[PROD_W-1:FRAC_W];
      res     = $signed({{(RES_W-CELL_W){1'b0}}, s3_ctr_ff}) + RES_W'(delta);
      if (res[RES_W-1])
         result.value = '0;
      else if (res[RES_W-2:CELL_W] != '0)
         result.value = '1;
      else
         result.value = res[CELL_W-1:0];
      result.last = s3_done_ff;
   end

   // ---------------- result queue ----------------
   result_type        fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PEND_W-1:0] fifo_cnt_ff, fifo_cnt_in;

   assign rsp_tvalid  = fifo_cnt_ff != '0;
   assign rsp_tdata   = fifo_mem[rd_ptr_ff].value;
   assign rsp_tlast   = fifo_mem[rd_ptr_ff].last;
   assign out_fire    = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + PEND_W'(s3_valid_ff) - PEND_W'(out_fire);

   always_ff @(posedge clock) begin
      if (s3_valid_ff)
         fifo_mem[wr_ptr_ff] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s3_valid_ff)
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (out_fire)
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

endmodule

### src/gds_checker.sv
// gds_checker: port-level assertions for grid_diffusion_stencil, bound to the top level.
// No package dependency.

module gds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   // queue and pipeline are empty after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // with nothing in flight the block takes input straight after reset
   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind grid_diffusion_stencil gds_checker u_gds_checker (.*);

### verif/tb.sv
// tb: self-checking bench for grid_diffusion_stencil; a diffused-cell predictor fills a
// scoreboard that every result transfer is checked against, with random gaps and stalls.
// Depends on gds_pkg and grid_diffusion_stencil.

module tb;
   import gds_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;   // no register behind this index
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned DRAIN_WAIT = 10;
   localparam longint CELL_TOP = 64'h0000_0000_FFFF_FFFF;

   class diffusion_scoreboard;
      bit [CELL_W-1:0]  upper_row [DEF_MAX_LINE];
      bit [CELL_W-1:0]  centre_row[DEF_MAX_LINE];
      int unsigned      col, row;
      bit [COEFF_W-1:0] coeff;
      bit [LEN_W-1:0]   len_reg;
      bit [CNT_W-1:0]   cnt_reg;
      result_type       expected_cells[$];
      int unsigned      mismatches, checked, cells_in, grids;

      function new();
         coeff   = COEFF_RESET;
         len_reg = LEN_RESET;
         cnt_reg = CNT_RESET;
         col = 0;
         row = 0;
      endfunction

      function int unsigned pending();
         return expected_cells.size();
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, bit [31:0] value);
         case (idx)
            REG_COEFF: coeff = value[COEFF_W-1:0];
            REG_LEN: begin
               len_reg = value[LEN_W-1:0];
               col = 0;
               row = 0;
            end
            REG_CNT: begin
               cnt_reg = value[CNT_W-1:0];
               col = 0;
               row = 0;
            end
            default: ;
         endcase
      endfunction

      function int unsigned line_len();
         if (len_reg < MIN_DIM) return MIN_DIM;
         if (len_reg > DEF_MAX_LINE) return DEF_MAX_LINE;
         return len_reg;
      endfunction

      function int unsigned line_cnt();
         if (cnt_reg < MIN_DIM) return MIN_DIM;
         if (cnt_reg > DEF_MAX_LINES) return DEF_MAX_LINES;
         return cnt_reg;
      endfunction

      // c + d*(up + dn + lf + rt - 4c), product rounded half up, clamped to the cell range
      function bit [CELL_W-1:0] diffuse(bit [CELL_W-1:0] ctr, bit [CELL_W-1:0] up,
                                        bit [CELL_W-1:0] dn, bit [CELL_W-1:0] lf,
                                        bit [CELL_W-1:0] rt);
         longint d, lc, lu, ld, ll, lr, diff, res;
         d  = (coeff > COEFF_MAX) ? COEFF_MAX : coeff;
         lc = ctr;
         lu = up;
         ld = dn;
         ll = lf;
         lr = rt;
         diff = lu + ld + ll + lr - 4 * lc;
         res = lc + ((diff * d + 32768) >>> FRAC_W);
         if (res < 0) res = 0;
         else if (res > CELL_TOP) res = CELL_TOP;
         return res[CELL_W-1:0];
      endfunction

      function void note_cell(bit [CELL_W-1:0] x);
         int unsigned n_len, n_cnt, c, r, k;
         bit [CELL_W-1:0] ctr, up, lf, rt;
         result_type item;
         n_len = line_len();
         n_cnt = line_cnt();
         c = col;
         r = row;
         cells_in++;
         if (c >= n_len) c = 0;
         if (r >= n_cnt) r = 0;
         // from the second line on, each transfer releases the cell one line above it
         if (r > 0) begin
            ctr = centre_row[c];
            up  = (r == 1) ? x : upper_row[c];
            if (c == 0) begin
               lf = centre_row[1];
               rt = lf;
            end else if (c + 1 >= n_len) begin
               lf = upper_row[c-1];
               rt = lf;
            end else begin
               lf = upper_row[c-1];
               rt = centre_row[c+1];
            end
            item.value = diffuse(ctr, up, x, lf, rt);
            item.last  = 1'b0;
            expected_cells.push_back(item);
            upper_row[c] = ctr;
         end
         centre_row[c] = x;
         c++;
         if (c >= n_len) begin
            c = 0;
            r++;
            if (r >= n_cnt) begin
               // last line: mirrored above and below
               for (k = 0; k < n_len; k++) begin
                  up = upper_row[k];
                  if (k == 0) begin
                     lf = centre_row[1];
                     rt = lf;
                  end else if (k + 1 >= n_len) begin
                     lf = centre_row[k-1];
                     rt = lf;
                  end else begin
                     lf = centre_row[k-1];
                     rt = centre_row[k+1];
                  end
                  item.value = diffuse(centre_row[k], up, up, lf, rt);
                  item.last  = (k + 1 == n_len);
                  expected_cells.push_back(item);
               end
               r = 0;
               grids++;
            end
         end
         col = c;
         row = r;
      endfunction

      function void check_cell(logic [CELL_W-1:0] value, logic last);
         result_type want;
         if (expected_cells.size() == 0) begin
            $error("unexpected result: new_value %h grid_done %b", value, last);
            mismatches++;
            return;
         end
         want = expected_cells.pop_front();
         checked++;
         if (value !== want.value) begin
            $error("new_value: expected %h, got %h", want.value, value);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("grid_done: expected %b, got %b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [CELL_W-1:0]     req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [CELL_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   diffusion_scoreboard sb;
   bit                  steady;      // no gaps or stalls while set
   int unsigned         idle_cycles;
   int unsigned         settings;

   grid_diffusion_stencil dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      return steady ? 0 : $urandom_range(19, 0);
   endfunction

   function automatic bit [CELL_W-1:0] draw_cell();
      case ($urandom_range(3, 0))
         0: return $urandom();
         1: return $urandom_range(1, 0) ? '1 : '0;
         2: return $urandom_range(255, 0);
         default: return {16'hFFFF, 16'($urandom())};
      endcase
   endfunction

   // both sides are sampled before the edge's updates land
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready === 1'b1) sb.note_cell(req_tdata);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_cell(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin : result_sink
      int unsigned stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   task automatic send_cell(input bit [CELL_W-1:0] x);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_random(input int unsigned n);
      repeat (n) send_cell(draw_cell());
   endtask

   // back-to-back writes keep psel high; the caller closes the bus
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input bit [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_reg(idx, value);
   endtask

   task automatic configure(input bit [31:0] coeff, input bit [31:0] len,
                            input bit [31:0] cnt);
      write_reg(REG_SPARE, $urandom());
      write_reg(REG_COEFF, coeff);
      write_reg(REG_LEN, len);
      write_reg(REG_CNT, cnt);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings++;
   endtask

   // wait out every expected result, then the pipeline of a result-free first line
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned len;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // smallest grid at the largest coefficient; second grid hits both rounding halves
      steady = 1'b1;
      configure(COEFF_MAX, MIN_DIM, MIN_DIM);
      send_cell('0);
      send_cell('1);
      send_cell('1);
      send_cell('0);
      send_cell(1);
      send_cell(1);
      send_cell(0);
      send_cell(0);
      finish_phase();

      // 3x3 with middle column; coefficient above the cap
      steady = 1'b0;
      configure(15'h7FFF, 3, 3);
      send_cell('1);
      send_cell('0);
      send_cell(32'h1234_5678);
      send_cell('0);
      send_cell('1);
      send_cell('0);
      send_cell(32'h8000_0000);
      send_cell(32'h7FFF_FFFF);
      send_cell(1);
      finish_phase();

      // sizes below the minimum fall back to 2
      steady = ($urandom_range(2, 0) == 0);
      configure(0, 0, 1);
      send_random(4);
      finish_phase();

      steady = ($urandom_range(2, 0) == 0);
      configure($urandom_range(COEFF_MAX, 0), 1, 0);
      send_random(8);
      finish_phase();

      // line length beyond the buffer clamps to a full line
      steady = ($urandom_range(2, 0) == 0);
      configure($urandom_range(32767, 0), 6'h3F, MIN_DIM);
      send_random(2 * DEF_MAX_LINE);
      finish_phase();

      // mid-sized grid, then possibly part of the next one, abandoned by the following write
      steady = ($urandom_range(2, 0) == 0);
      len = $urandom_range(6, 3);
      configure($urandom_range(32767, 0), len, $urandom_range(4, 3));
      send_random(sb.line_len() * sb.line_cnt() + $urandom_range(len - 1, 0));
      finish_phase();

      // full-width lines with the line count clamped high; stops part way through
      steady = ($urandom_range(2, 0) == 0);
      configure($urandom_range(32767, 0), DEF_MAX_LINE, 13'h1FFF);
      send_random(36);
      finish_phase();

      $display("tb: %0d cells over %0d register settings, %0d results checked",
               sb.cells_in, settings, sb.checked);
      $display("tb: %0d complete grids, %0d mismatches", sb.grids, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
